// ----- rtl/ffe_pkg.sv -----
// ----------------------------------------------------------------------------
// ffe_pkg - shared types and constants of the feedforward/feedback echo
// Word types of both channels, register codes and reset values, and the
// entry that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package ffe_pkg;

  localparam int ChannelsDef  = 2;
  localparam int RingDepthDef = 65536;

  localparam int TapW     = 16;
  localparam int SampleW  = 24;
  localparam int GainW    = 16;
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;

  typedef enum logic [1:0] {
    RegDelay    = 2'd0,
    RegDirect   = 2'd1,
    RegForward  = 2'd2,
    RegFeedback = 2'd3
  } reg_idx_e;

  localparam logic [TapW-1:0]         DelayRst    = 16'h0000;
  localparam logic signed [GainW-1:0] DirectRst   = 16'sh4000;
  localparam logic signed [GainW-1:0] ForwardRst  = 16'sh0000;
  localparam logic signed [GainW-1:0] FeedbackRst = 16'sh0000;

  typedef struct packed {
    logic                      chan;
    logic signed [SampleW-1:0] sample_in;
  } in_word_t;

  typedef struct packed {
    logic                      chan_out;
    logic signed [SampleW-1:0] sample_out;
  } out_word_t;

  typedef struct packed {
    logic [TapW-1:0]         delay_samples;
    logic signed [GainW-1:0] direct_gain;
    logic signed [GainW-1:0] forward_gain;
    logic signed [GainW-1:0] feedback_gain;
  } cfg_t;

  // Classified word: taps already reduced modulo the ring depth.
  typedef struct packed {
    logic                      bypass;
    logic                      chan;
    logic signed [SampleW-1:0] sample;
    logic [TapW-1:0]           tap_fwd;
    logic [TapW-1:0]           tap_fb;
  } task_t;

endpackage

// ----- rtl/feedforward_feedback_echo.sv -----
// ----------------------------------------------------------------------------
// feedforward_feedback_echo - per-channel feedforward/feedback echo
// Computes y = g0*x + gf*x[n-D] - gb*y[n-D/2] per channel with input and
// output delay rings, Q2.14 gains and a saturated 24-bit result.
// ----------------------------------------------------------------------------
// The block takes one word per cycle while in_stall_o is low into a
// four-entry queue; the back end starts no word while stage 1 holds one, as
// a word's ring tap reads wait for the previous word's write-back. A word
// passes the front register, the queue, stages 1 and 2 and the output
// register. Both rings start as all zero without any clearing pass: per
// channel, the write pointer and a full-lap flag tell which entries have
// been written, and the rest read as zero. A delay of zero, or a channel
// number of CHANNELS or more, passes the sample through and leaves all
// history untouched. Write configuration only while no word is in flight.
module feedforward_feedback_echo #(
  parameter int CHANNELS   = ffe_pkg::ChannelsDef,
  parameter int RING_DEPTH = ffe_pkg::RingDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ffe_pkg::in_word_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ffe_pkg::out_word_t            out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffe_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ffe_pkg::CfgDataW-1:0]  pwdata,
  output logic [ffe_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import ffe_pkg::*;

  cfg_t  cfg;
  task_t push_word, head_word;
  logic  push, pop, full, empty;

  ffe_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ffe_front #(
    .CHANNELS   (CHANNELS),
    .RING_DEPTH (RING_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .task_o     (push_word)
  );

  ffe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_word),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head_word)
  );

  ffe_back #(
    .CHANNELS   (CHANNELS),
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .empty_i     (empty),
    .task_i      (head_word),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/ffe_cfg.sv -----
// ----------------------------------------------------------------------------
// ffe_cfg - configuration registers
// APB-style register file holding the delay and the three gains.
// ----------------------------------------------------------------------------
module ffe_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffe_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ffe_pkg::CfgDataW-1:0]  pwdata,
  output logic [ffe_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output ffe_pkg::cfg_t                 cfg_o
);
  import ffe_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[CfgAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_samples <= DelayRst;
      cfg_q.direct_gain   <= DirectRst;
      cfg_q.forward_gain  <= ForwardRst;
      cfg_q.feedback_gain <= FeedbackRst;
    end else if (wr_en) begin
      unique case (idx)
        RegDelay:    cfg_q.delay_samples <= pwdata[TapW-1:0];
        RegDirect:   cfg_q.direct_gain   <= pwdata[GainW-1:0];
        RegForward:  cfg_q.forward_gain  <= pwdata[GainW-1:0];
        RegFeedback: cfg_q.feedback_gain <= pwdata[GainW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegDelay:    prdata = CfgDataW'(cfg_q.delay_samples);
      RegDirect:   prdata = CfgDataW'(unsigned'(cfg_q.direct_gain));
      RegForward:  prdata = CfgDataW'(unsigned'(cfg_q.forward_gain));
      RegFeedback: prdata = CfgDataW'(unsigned'(cfg_q.feedback_gain));
    endcase
  end

endmodule

// ----- rtl/ffe_front.sv -----
// ----------------------------------------------------------------------------
// ffe_front - accept and classify
// Takes input words, marks bypass words and reduces both tap delays modulo
// the ring depth (reciprocal multiply, then multiply-subtract) before the
// word enters the queue.
// ----------------------------------------------------------------------------
module ffe_front #(
  parameter int CHANNELS   = ffe_pkg::ChannelsDef,
  parameter int RING_DEPTH = ffe_pkg::RingDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ffe_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ffe_pkg::in_word_t in_data_i,
  input  logic              full_i,
  output logic              push_o,
  output ffe_pkg::task_t    task_o
);
  import ffe_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int K     = TapW + PTR_W;
  localparam logic [63:0] RECIP = ((64'd1 << K) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
  localparam int RW    = $clog2(RECIP + 64'd1);
  localparam int PW    = TapW + RW;
  localparam int MW    = TapW + PTR_W + 1;
  localparam logic [MW-1:0] DEPTH_V = MW'(RING_DEPTH);

  logic            f1_valid_q;
  in_word_t        f1_word_q;
  logic            f1_bypass_q;
  logic [TapW-1:0] qf_q, qb_q;

  logic            load;
  logic            bypass_d;
  logic [TapW-1:0] tap_fb_raw;
  logic [PW-1:0]   prod_f, prod_b;
  logic [MW-1:0]   diff_f, diff_b;

  assign in_stall_o = f1_valid_q && full_i;
  assign push_o     = f1_valid_q && !full_i;
  assign load       = in_valid_i && !in_stall_o;

  assign tap_fb_raw = cfg_i.delay_samples >> 1;
  assign bypass_d   = (cfg_i.delay_samples == '0) || (int'(in_data_i.chan) >= CHANNELS);

  // Quotient estimate: exact for every 16-bit tap with this reciprocal.
  assign prod_f = PW'(cfg_i.delay_samples) * PW'(RECIP);
  assign prod_b = PW'(tap_fb_raw) * PW'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= load || (f1_valid_q && !push_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      f1_word_q   <= in_data_i;
      f1_bypass_q <= bypass_d;
      qf_q        <= TapW'(prod_f >> K);
      qb_q        <= TapW'(prod_b >> K);
    end
  end

  // Remainder: tap minus quotient times depth.
  assign diff_f = MW'(cfg_i.delay_samples) - MW'(qf_q) * DEPTH_V;
  assign diff_b = MW'(tap_fb_raw) - MW'(qb_q) * DEPTH_V;

  always_comb begin
    task_o.bypass  = f1_bypass_q;
    task_o.chan    = f1_word_q.chan;
    task_o.sample  = f1_word_q.sample_in;
    task_o.tap_fwd = TapW'(diff_f);
    task_o.tap_fb  = TapW'(diff_b);
  end

endmodule

// ----- rtl/ffe_queue.sv -----
// ----------------------------------------------------------------------------
// ffe_queue - decoupling queue
// Four-entry FIFO of classified words between the front and back ends.
// ----------------------------------------------------------------------------
module ffe_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ffe_pkg::task_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ffe_pkg::task_t data_o
);
  import ffe_pkg::*;

  localparam int Depth = 4;
  localparam int AW    = $clog2(Depth);

  task_t           slot_q [Depth];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [AW:0]     count_q;

  assign full_o  = (count_q == (AW + 1)'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= data_i;
  end

endmodule

// ----- rtl/ffe_back.sv -----
// ----------------------------------------------------------------------------
// ffe_back - ring access and multiply-add
// Issues ring reads, forms the three products, rounds and saturates the sum,
// writes both rings and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module ffe_back #(
  parameter int CHANNELS   = ffe_pkg::ChannelsDef,
  parameter int RING_DEPTH = ffe_pkg::RingDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ffe_pkg::cfg_t      cfg_i,
  input  logic               empty_i,
  input  ffe_pkg::task_t     task_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ffe_pkg::out_word_t out_data_o
);
  import ffe_pkg::*;

  localparam int NCH   = (CHANNELS < 2) ? CHANNELS : 2;
  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int ProdW = SampleW + GainW;
  localparam int SumW  = ProdW + 2;
  localparam int QW    = SumW - 14;
  localparam logic [PTR_W:0]   DEPTH_V  = (PTR_W + 1)'(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic signed [SampleW-1:0] SatMax = {1'b0, {(SampleW - 1){1'b1}}};
  localparam logic signed [SampleW-1:0] SatMin = {1'b1, {(SampleW - 1){1'b0}}};

  function automatic logic chan_idx(input logic chan);
    return (NCH > 1) ? chan : 1'b0;
  endfunction

  function automatic logic [PTR_W-1:0] tap_addr(input logic [PTR_W-1:0] wp,
                                                input logic [PTR_W-1:0] tap);
    logic [PTR_W:0] wrapped;
    wrapped = {1'b0, wp} + DEPTH_V - {1'b0, tap};
    return (wp >= tap) ? (wp - tap) : wrapped[PTR_W-1:0];
  endfunction

  logic signed [SampleW-1:0] in_ring_q  [NCH][RING_DEPTH];
  logic signed [SampleW-1:0] out_ring_q [NCH][RING_DEPTH];

  logic [PTR_W-1:0] wp_q [NCH];
  logic [NCH-1:0]   wrap_q;

  logic adv;

  // issue
  logic             ci;
  logic [PTR_W-1:0] wp_cur, addr_fwd, addr_fb;
  logic             vf_d, vb_d, hf_d, hb_d;

  // stage 1: ring data back
  logic                      b1_valid_q, b1_bypass_q, b1_chan_q;
  logic signed [SampleW-1:0] b1_x_q, xrd_q, yrd_q;
  logic [PTR_W-1:0]          b1_addr_q;
  logic                      b1_vf_q, b1_vb_q, b1_hf_q, b1_hb_q;
  logic signed [SampleW-1:0] xd, yd;

  // stage 2: products
  logic                      b2_valid_q, b2_bypass_q, b2_chan_q;
  logic signed [SampleW-1:0] b2_x_q;
  logic [PTR_W-1:0]          b2_addr_q;
  logic signed [ProdW-1:0]   p0_q, pf_q, pb_q;
  logic                      b2_wr, b2_ci;
  logic signed [SumW-1:0]    sum;
  logic signed [QW-1:0]      quo;
  logic signed [SampleW-1:0] y_sat, y_out;

  // last ring write, for a read issued at the same edge
  logic signed [SampleW-1:0] fx_q, fy_q;

  logic      out_valid_q;
  out_word_t out_word_q;

  assign adv   = !out_valid_q || !out_stall_i;
  // Start no word while stage 1 holds one, so each read sees the previous write-back.
  assign pop_o = adv && !empty_i && !b1_valid_q;

  assign ci       = chan_idx(task_i.chan);
  assign wp_cur   = wp_q[ci];
  assign addr_fwd = tap_addr(wp_cur, PTR_W'(task_i.tap_fwd));
  assign addr_fb  = tap_addr(wp_cur, PTR_W'(task_i.tap_fb));
  // Entries below the write pointer, or all after a full lap, hold real data.
  assign vf_d     = wrap_q[ci] || (addr_fwd < wp_cur);
  assign vb_d     = wrap_q[ci] || (addr_fb < wp_cur);

  assign b2_wr    = b2_valid_q && !b2_bypass_q;
  assign b2_ci    = chan_idx(b2_chan_q);
  assign hf_d     = b2_wr && (b2_ci == ci) && (b2_addr_q == addr_fwd);
  assign hb_d     = b2_wr && (b2_ci == ci) && (b2_addr_q == addr_fb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCH; i++) wp_q[i] <= '0;
      wrap_q <= '0;
    end else if (pop_o && !task_i.bypass) begin
      wp_q[ci] <= (wp_cur == PTR_LAST) ? '0 : wp_cur + 1'b1;
      if (wp_cur == PTR_LAST) wrap_q[ci] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && b2_wr) in_ring_q[b2_ci][b2_addr_q] <= b2_x_q;
    if (pop_o) xrd_q <= in_ring_q[ci][addr_fwd];
  end

  always_ff @(posedge clk_i) begin
    if (adv && b2_wr) out_ring_q[b2_ci][b2_addr_q] <= y_sat;
    if (pop_o) yrd_q <= out_ring_q[ci][addr_fb];
  end

  always_comb begin
    xd = b1_hf_q ? fx_q : (b1_vf_q ? xrd_q : '0);
    yd = b1_hb_q ? fy_q : (b1_vb_q ? yrd_q : '0);
  end

  // Round half up at bit 14, floor, then clamp to the sample range.
  always_comb begin
    sum = SumW'(p0_q) + SumW'(pf_q) - SumW'(pb_q) + SumW'(15'sd8192);
    quo = QW'(sum >>> 14);
    if (!quo[QW-1] && (|quo[QW-2:SampleW-1])) begin
      y_sat = SatMax;
    end else if (quo[QW-1] && !(&quo[QW-2:SampleW-1])) begin
      y_sat = SatMin;
    end else begin
      y_sat = quo[SampleW-1:0];
    end
    y_out = b2_bypass_q ? b2_x_q : y_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      b1_valid_q  <= pop_o;
      b2_valid_q  <= b1_valid_q;
      out_valid_q <= b2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_bypass_q <= task_i.bypass;
      b1_chan_q   <= task_i.chan;
      b1_x_q      <= task_i.sample;
      b1_addr_q   <= wp_cur;
      b1_vf_q     <= vf_d;
      b1_vb_q     <= vb_d;
      b1_hf_q     <= hf_d;
      b1_hb_q     <= hb_d;

      b2_bypass_q <= b1_bypass_q;
      b2_chan_q   <= b1_chan_q;
      b2_x_q      <= b1_x_q;
      b2_addr_q   <= b1_addr_q;
      p0_q        <= ProdW'(cfg_i.direct_gain) * ProdW'(b1_x_q);
      pf_q        <= ProdW'(cfg_i.forward_gain) * ProdW'(xd);
      pb_q        <= ProdW'(cfg_i.feedback_gain) * ProdW'(yd);

      out_word_q.chan_out   <= b2_chan_q;
      out_word_q.sample_out <= y_out;
    end
    if (adv && b2_wr) begin
      fx_q <= b2_x_q;
      fy_q <= y_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

endmodule

// ----- rtl/ffe_checker.sv -----
// ----------------------------------------------------------------------------
// ffe_checker - port-level checks of the echo block
// Watches the word channels and the register port of the top level.
// ----------------------------------------------------------------------------
module ffe_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input ffe_pkg::out_word_t            out_data_o,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [ffe_pkg::CfgAddrW-1:0]  paddr,
  input logic [ffe_pkg::CfgDataW-1:0]  pwdata,
  input logic [ffe_pkg::CfgDataW-1:0]  prdata,
  input logic                          pready
);
  import ffe_pkg::*;

  logic [TapW-1:0] shadow_q [4];
  logic [4:0]      pending_q;
  logic            in_acc, out_acc;
  logic [1:0]      idx;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign idx     = paddr[CfgAddrW-1:2];

  // Track words accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  // Mirror the register file from the write transfers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_q[RegDelay]    <= DelayRst;
      shadow_q[RegDirect]   <= DirectRst;
      shadow_q[RegForward]  <= ForwardRst;
      shadow_q[RegFeedback] <= FeedbackRst;
    end else if (psel && penable && pwrite && pready) begin
      shadow_q[idx] <= pwdata[TapW-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result word changed");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("result word without an accepted input word");

  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && !pwrite |-> prdata == CfgDataW'(shadow_q[idx]))
    else $error("register read does not match last write");

endmodule

bind feedforward_feedback_echo ffe_checker u_ffe_checker (.*);

// ----- tb/ffe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffe_scoreboard - scoreboard for the feedforward/feedback echo
// Follows register writes on the config port, keeps its own per-channel
// input and output rings, computes the echo for every accepted input word
// and compares each accepted output word against the oldest prediction.
// Register readbacks are checked against the tracked settings.
// ----------------------------------------------------------------------------
module ffe_scoreboard
  import ffe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_word_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_word_t           out_data_i,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  input  logic [CfgDataW-1:0] prdata,
  input  logic                pready,
  output int                  errors_o,
  output int                  pending_o,
  output int                  words_o,
  output int                  saturated_o,
  output int                  bypassed_o,
  output int                  reads_o
);

  localparam int     Depth     = RingDepthDef;
  localparam longint SampleMax = (longint'(1) <<< (SampleW - 1)) - 1;
  localparam longint SampleMin = -(longint'(1) <<< (SampleW - 1));

  cfg_t                    echo_cfg;
  bit signed [SampleW-1:0] in_ring  [ChannelsDef][Depth];
  bit signed [SampleW-1:0] out_ring [ChannelsDef][Depth];
  int unsigned             wr_pos   [ChannelsDef];
  out_word_t               echo_q[$];

  int n_errors, n_words, n_saturated, n_bypassed, n_reads;

  assign errors_o    = n_errors;
  assign words_o     = n_words;
  assign saturated_o = n_saturated;
  assign bypassed_o  = n_bypassed;
  assign reads_o     = n_reads;

  task automatic report_mismatch(input string what, input int want, input int got);
    n_errors++;
    if (n_errors <= 10) begin
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  function automatic logic [GainW-1:0] reg_value(input reg_idx_e idx);
    case (idx)
      RegDelay:    return echo_cfg.delay_samples;
      RegDirect:   return echo_cfg.direct_gain;
      RegForward:  return echo_cfg.forward_gain;
      default:     return echo_cfg.feedback_gain;
    endcase
  endfunction

  // Compute y = g0*x + gf*x[n-D] - gb*y[n-D/2] and advance the channel's rings.
  function automatic out_word_t echo_sample(input in_word_t w);
    out_word_t   y;
    int unsigned ch, wp, delay, fwd_addr, fb_addr;
    longint      acc;
    y.chan_out   = w.chan;
    y.sample_out = w.sample_in;
    ch           = w.chan;
    delay        = echo_cfg.delay_samples;
    if (delay == 0 || ch >= ChannelsDef) begin
      n_bypassed++;
      return y;
    end
    wp       = wr_pos[ch];
    fwd_addr = (wp + Depth - delay % Depth) % Depth;
    fb_addr  = (wp + Depth - (delay >> 1) % Depth) % Depth;
    acc = longint'($signed(echo_cfg.direct_gain)) * longint'($signed(w.sample_in))
        + longint'($signed(echo_cfg.forward_gain)) * longint'(in_ring[ch][fwd_addr])
        - longint'($signed(echo_cfg.feedback_gain)) * longint'(out_ring[ch][fb_addr]);
    // round half up to Q1.23, then clamp
    acc = (acc + 64'sd8192) >>> 14;
    if (acc > SampleMax) begin
      acc = SampleMax;
      n_saturated++;
    end else if (acc < SampleMin) begin
      acc = SampleMin;
      n_saturated++;
    end
    y.sample_out      = acc[SampleW-1:0];
    in_ring[ch][wp]   = w.sample_in;
    out_ring[ch][wp]  = y.sample_out;
    wr_pos[ch]        = (wp + 1) % Depth;
    return y;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      echo_cfg = '{DelayRst, DirectRst, ForwardRst, FeedbackRst};
      foreach (wr_pos[c]) wr_pos[c] = 0;
      echo_q.delete();
      pending_o <= 0;
    end else begin
      // check output first: a word accepted at this edge cannot come out yet
      if (out_valid_i && !out_stall_i) begin
        if (echo_q.size() == 0) begin
          report_mismatch("unexpected result, sample", 0,
                          int'($signed(out_data_i.sample_out)));
        end else begin
          want = echo_q.pop_front();
          if (out_data_i.chan_out !== want.chan_out) begin
            report_mismatch("chan_out", int'(want.chan_out), int'(out_data_i.chan_out));
          end
          if (out_data_i.sample_out !== want.sample_out) begin
            report_mismatch("sample_out", int'($signed(want.sample_out)),
                            int'($signed(out_data_i.sample_out)));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        n_words++;
        echo_q.push_back(echo_sample(in_data_i));
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_e'(paddr[3:2]))
            RegDelay:    echo_cfg.delay_samples = pwdata[TapW-1:0];
            RegDirect:   echo_cfg.direct_gain   = pwdata[GainW-1:0];
            RegForward:  echo_cfg.forward_gain  = pwdata[GainW-1:0];
            RegFeedback: echo_cfg.feedback_gain = pwdata[GainW-1:0];
            default: ;
          endcase
        end else begin
          n_reads++;
          if (prdata[GainW-1:0] !== reg_value(reg_idx_e'(paddr[3:2]))) begin
            report_mismatch("register readback", int'(reg_value(reg_idx_e'(paddr[3:2]))),
                            int'(prdata[GainW-1:0]));
          end
        end
      end
      pending_o <= echo_q.size();
    end
  end

endmodule

// ----- tb/feedforward_feedback_echo_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedforward_feedback_echo_test - top of the echo testbench
// Drives directed and random sample words through the echo under a series of
// register settings, with random gaps on both sides, a long output hold-off
// that backs up the input, and drains between settings; the checker beside
// the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module feedforward_feedback_echo_test;
  import ffe_pkg::*;

  localparam int HoldCycles = 80;
  localparam int Phases     = 12;
  localparam int PhaseWords = 60;

  localparam logic signed [SampleW-1:0] SampleHi = 24'sh7FFFFF;
  localparam logic signed [SampleW-1:0] SampleLo = 24'sh800000;
  localparam logic signed [GainW-1:0]   GainHi   = 16'sh7FFF;
  localparam logic signed [GainW-1:0]   GainLo   = 16'sh8000;
  localparam logic signed [GainW-1:0]   GainOne  = 16'sh4000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_word_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_word_t           out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [CfgAddrW-1:0] paddr       = '0;
  logic [CfgDataW-1:0] pwdata      = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  bit send_idle    = 1'b1;
  bit recv_idle    = 1'b1;
  bit hold_request = 1'b0;
  int n_settings;
  int errors, pending, words, saturated, bypassed, reads;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  feedforward_feedback_echo uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ffe_scoreboard echo_check (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .errors_o(errors), .pending_o(pending), .words_o(words),
    .saturated_o(saturated), .bypassed_o(bypassed), .reads_o(reads)
  );

  function automatic in_word_t sample_word(input logic ch, input logic signed [SampleW-1:0] s);
    return in_word_t'{chan: ch, sample_in: s};
  endfunction

  function automatic logic signed [SampleW-1:0] rand_sample();
    case ($urandom_range(15, 0))
      0:       return SampleHi;
      1:       return SampleLo;
      2:       return '0;
      3:       return '1;
      default: return SampleW'($urandom);
    endcase
  endfunction

  function automatic logic signed [GainW-1:0] rand_gain();
    case ($urandom_range(7, 0))
      0:       return GainLo;
      1:       return GainHi;
      2:       return '0;
      3:       return GainOne;
      default: return GainW'($urandom);
    endcase
  endfunction

  // mostly short delays so the taps land on written history
  function automatic logic [TapW-1:0] rand_delay();
    int r;
    r = $urandom_range(19, 0);
    if (r < 2) return '0;
    if (r < 12) return TapW'($urandom_range(16, 1));
    if (r < 15) return TapW'($urandom_range(400, 17));
    if (r < 18) return TapW'($urandom_range(65535, 65000));
    return TapW'($urandom);
  endfunction

  // Leave valid high on return: the caller drops it or the next word follows.
  task automatic push_word(input in_word_t w);
    int gap;
    gap = send_idle ? $urandom_range(13, 0) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [CfgDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic cfg_read(input reg_idx_e idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // Drain the block, then load and read back all four registers.
  task automatic set_echo(input logic [TapW-1:0] delay, input logic signed [GainW-1:0] g0,
                          input logic signed [GainW-1:0] gf, input logic signed [GainW-1:0] gb);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    cfg_write(RegDelay, {16'h0000, delay});
    cfg_write(RegDirect, {{16{g0[GainW-1]}}, g0});
    cfg_write(RegForward, {{16{gf[GainW-1]}}, gf});
    cfg_write(RegFeedback, {{16{gb[GainW-1]}}, gb});
    cfg_read(RegDelay);
    cfg_read(RegDirect);
    cfg_read(RegForward);
    cfg_read(RegFeedback);
    psel    <= 1'b0;
    penable <= 1'b0;
    n_settings++;
  endtask

  // Output side: random stall per word, one long hold-off on request.
  initial begin
    int stall_len;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall_len    = HoldCycles;
      end else begin
        stall_len = recv_idle ? $urandom_range(13, 0) : 0;
      end
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d results still expected", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: delay zero, so every word passes through
    push_word(sample_word(1'b0, SampleHi));
    push_word(sample_word(1'b1, SampleLo));
    push_word(sample_word(1'b0, '0));
    push_word(sample_word(1'b1, '1));

    // delay one: feedback tap reads the slot about to be overwritten
    set_echo(16'd1, GainOne, GainHi, GainLo);
    push_word(sample_word(1'b0, SampleHi));
    push_word(sample_word(1'b0, SampleLo));
    push_word(sample_word(1'b0, 24'sh123456));
    push_word(sample_word(1'b1, 24'sh400000));

    // full-scale gains and samples: clamp at both ends
    set_echo(16'd2, GainHi, GainLo, GainHi);
    push_word(sample_word(1'b0, SampleHi));
    push_word(sample_word(1'b0, SampleLo));
    push_word(sample_word(1'b0, SampleHi));
    push_word(sample_word(1'b0, SampleLo));
    push_word(sample_word(1'b1, SampleHi));
    push_word(sample_word(1'b1, SampleLo));

    // largest delay: taps wrap below address zero
    set_echo(16'hFFFF, GainLo, GainOne, GainOne);
    push_word(sample_word(1'b0, SampleLo));
    push_word(sample_word(1'b0, 24'sh000001));
    push_word(sample_word(1'b1, SampleHi));

    set_echo(16'd3, GainLo, GainLo, GainLo);
    push_word(sample_word(1'b1, SampleLo));
    push_word(sample_word(1'b1, SampleLo));
    push_word(sample_word(1'b1, SampleHi));
    push_word(sample_word(1'b1, SampleHi));

    // bypass again with all gains cleared
    set_echo(16'd0, '0, '0, '0);
    push_word(sample_word(1'b0, 24'sh5A5A5A));
    push_word(sample_word(1'b1, 24'shA5A5A5));

    for (int p = 0; p < Phases; p++) begin
      send_idle = (p != 4) && (p != 7);
      recv_idle = (p != 7);
      set_echo(rand_delay(), rand_gain(), rand_gain(), rand_gain());
      // back up the output so the input queue fills and stalls
      if (p == 4) hold_request = 1'b1;
      repeat (PhaseWords) push_word(sample_word(1'($urandom_range(1, 0)), rand_sample()));
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (12) @(posedge clk_i);

    $display("Ran %0d samples under %0d register settings with %0d readbacks;",
             words, n_settings, reads);
    $display("%0d samples went through unchanged, %0d results hit the clamp",
             bypassed, saturated);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
